[rtl/core/tmh_pkg.sv]
// Shared types and constants for the timestamp min-heap merge unit.
`default_nettype none
package tmh_pkg;

  localparam int MAX_SOURCES = 16;
  localparam int KEY_W       = 64;
  localparam int SRC_W       = 4;
  localparam int IDX_W       = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
  localparam int CHILD_W     = IDX_W + 2;

  localparam logic       ACT_INSERT = 1'b0;
  localparam logic       ACT_POP    = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PLOAD,
    S_DOWN,
    S_PUT
  } state_t;

endpackage
`default_nettype wire

[rtl/core/tmh_store.sv]
// Heap entry store: one write port, two registered read ports.
`default_nettype none
module tmh_store
  import tmh_pkg::*;
(
  input  wire logic             clk,
  input  wire wr_t              wr,
  input  wire logic [IDX_W-1:0] rd_addr_a,
  input  wire logic [IDX_W-1:0] rd_addr_b,
  output entry_t                rd_data_a,
  output entry_t                rd_data_b
);

  entry_t mem [MAX_SOURCES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

[rtl/core/timestamp_min_heap_merge_unit.sv]
// Top level: binary min-heap of (source, timestamp) entries for k-way merge.
//
// Request channel: a request is taken at a rising edge with start high and
// busy low. action selects insert (source_id, event_time are stored) or pop
// (the smallest entry is returned). Exactly one result follows each request:
// done is high for one cycle with status, popped_source, popped_time and
// entry_count valid. The receiver cannot stall, so results are never held.
//
// Timing: a pop on an empty heap, an insert into a full heap and an insert
// into an empty heap answer in the cycle after the request. A pop that leaves
// zero or one entry answers from S_PLOAD. Other requests walk the heap one
// level per cycle through a read-compare-write on the entry store: an insert
// climbs in S_UP, a pop loads root and last entry in S_PLOAD and descends in
// S_DOWN, and both may end in S_PUT. The sequencer handles one request at a
// time; busy stays high until the cycle the result appears, and a new request
// may be taken while done is high.
//
// The moving entry is carried in a register and written once at its final
// slot; parents or children it passes are shifted by one write per level.
// Reset clears only the fill count, the sequencer and done; entries at or
// beyond the fill count are never used.
`default_nettype none
module timestamp_min_heap_merge_unit
  import tmh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             action,
  input  wire logic [SRC_W-1:0] source_id,
  input  wire logic [KEY_W-1:0] event_time,
  output logic                  done,
  output logic [1:0]            status,
  output logic [SRC_W-1:0]      popped_source,
  output logic [KEY_W-1:0]      popped_time,
  output logic [CNT_W-1:0]      entry_count
);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_SOURCES);

  state_t           state, state_next;
  logic [IDX_W-1:0] pos, pos_next;
  entry_t           carried, carried_next;
  logic [CNT_W-1:0] count, count_next;
  logic             finish;
  logic [1:0]       status_next;
  logic [SRC_W-1:0] psrc, psrc_next;
  logic [KEY_W-1:0] ptime, ptime_next;

  wr_t              wr;
  logic [IDX_W-1:0] rd_addr_a, rd_addr_b;
  entry_t           rd_data_a, rd_data_b;

  // sift helpers
  logic [IDX_W-1:0]   parent;
  logic [IDX_W-1:0]   grand;
  logic [CHILD_W-1:0] c1, c2, nc1;
  logic [CHILD_W-1:0] count_ext;
  logic               take_first;
  logic [IDX_W-1:0]   pick;
  entry_t             pick_entry;

  tmh_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign parent    = (pos - IDX_W'(1)) >> 1;
  assign grand     = (parent - IDX_W'(1)) >> 1;
  assign count_ext = CHILD_W'(count);
  assign c1        = {1'b0, pos, 1'b1};
  assign c2        = c1 + CHILD_W'(1);
  // equal keys go to the second child; no second child means the first
  assign take_first = (c2 >= count_ext) || (rd_data_a.key < rd_data_b.key);
  assign pick       = take_first ? c1[IDX_W-1:0] : c2[IDX_W-1:0];
  assign pick_entry = take_first ? rd_data_a : rd_data_b;
  assign nc1        = {1'b0, pick, 1'b1};

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    carried_next = carried;
    count_next   = count;
    finish       = 1'b0;
    status_next  = ST_OK;
    psrc_next    = psrc;
    ptime_next   = ptime;
    wr           = '0;
    rd_addr_a    = '0;
    rd_addr_b    = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          carried_next = '{src: source_id, key: event_time};
          psrc_next    = '0;
          ptime_next   = '0;
          if (action == ACT_INSERT) begin
            if (count >= FULL_COUNT) begin
              finish      = 1'b1;
              status_next = ST_FULL;
            end else if (count == '0) begin
              wr.en      = 1'b1;
              wr.addr    = '0;
              wr.data    = '{src: source_id, key: event_time};
              count_next = CNT_W'(1);
              finish     = 1'b1;
            end else begin
              pos_next   = count[IDX_W-1:0];
              rd_addr_a  = (count[IDX_W-1:0] - IDX_W'(1)) >> 1;
              count_next = count + CNT_W'(1);
              state_next = S_UP;
            end
          end else begin
            if (count == '0) begin
              finish      = 1'b1;
              status_next = ST_EMPTY;
            end else begin
              rd_addr_a  = '0;
              rd_addr_b  = IDX_W'(count - CNT_W'(1));
              count_next = count - CNT_W'(1);
              state_next = S_PLOAD;
            end
          end
        end
      end

      S_UP: begin
        // rd_data_a holds the parent of pos
        if (rd_data_a.key > carried.key) begin
          wr.en    = 1'b1;
          wr.addr  = pos;
          wr.data  = rd_data_a;
          pos_next = parent;
          if (parent == '0) begin
            state_next = S_PUT;
          end else begin
            rd_addr_a = grand;
          end
        end else begin
          wr.en      = 1'b1;
          wr.addr    = pos;
          wr.data    = carried;
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_PLOAD: begin
        // rd_data_a is the root, rd_data_b the last entry; count is already reduced
        psrc_next    = rd_data_a.src;
        ptime_next   = rd_data_a.key;
        carried_next = rd_data_b;
        pos_next     = '0;
        if (count == '0) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end else if (count == CNT_W'(1)) begin
          wr.en      = 1'b1;
          wr.addr    = '0;
          wr.data    = rd_data_b;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_addr_a  = IDX_W'(1);
          rd_addr_b  = IDX_W'(2);
          state_next = S_DOWN;
        end
      end

      S_DOWN: begin
        // rd_data_a / rd_data_b hold the children of pos
        if (carried.key > pick_entry.key) begin
          wr.en    = 1'b1;
          wr.addr  = pos;
          wr.data  = pick_entry;
          pos_next = pick;
          if (nc1 < count_ext) begin
            rd_addr_a = nc1[IDX_W-1:0];
            rd_addr_b = nc1[IDX_W-1:0] + IDX_W'(1);
          end else begin
            state_next = S_PUT;
          end
        end else begin
          wr.en      = 1'b1;
          wr.addr    = pos;
          wr.data    = carried;
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_PUT: begin
        wr.en      = 1'b1;
        wr.addr    = pos;
        wr.data    = carried;
        finish     = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    carried <= carried_next;
    psrc    <= psrc_next;
    ptime   <= ptime_next;
    if (finish) begin
      status        <= status_next;
      popped_source <= psrc_next;
      popped_time   <= ptime_next;
      entry_count   <= count_next;
    end
  end

  // Writes during a sift always land inside the filled part of the heap.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (wr.en && state != S_IDLE) |-> (CNT_W'(wr.addr) < count))
    else $error("heap write beyond fill count");

  // A pop on an empty heap answers at once with empty status and no entry.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_POP && count == '0) |=>
      (done && status == ST_EMPTY && popped_time == '0 && entry_count == '0))
    else $error("pop on empty heap not flagged");

  // An insert into a full heap is dropped and the count stays at its maximum.
  a_insert_full: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_INSERT && count == FULL_COUNT) |=>
      (done && status == ST_FULL && count == FULL_COUNT))
    else $error("insert into full heap not flagged");

  // The sequencer never runs with no result owed: busy ends with a result.
  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    (busy && state_next == S_IDLE) |=> done)
    else $error("request finished without result");

endmodule
`default_nettype wire
